@@ rtl/ss_twr_response_range_macros.svh @@
// Assertion macros for the ranging response block checker
`ifndef SS_TWR_RESPONSE_RANGE_MACROS_SVH
`define SS_TWR_RESPONSE_RANGE_MACROS_SVH

// same-cycle implication on clk, off during rst
`define SSTWR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sstwr check failed");

// next-cycle implication on clk, off during rst
`define SSTWR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sstwr check failed");

`endif

@@ rtl/sstwr_pkg.sv @@
// Shared types, constants and header table for the ranging response block
`default_nettype none

package sstwr_pkg;

  localparam int HEADER_BYTES = 10;
  localparam int BUFFER_BYTES = 20;
  localparam int SEQ_POS      = 2;
  localparam int POLL_POS     = 10;
  localparam int RESP_POS     = 14;
  localparam int CFG_DATA_W   = 24;

  localparam logic signed [23:0] OFFSET_SCALE_RST   = -24'sd630150;
  localparam logic [19:0]        DISTANCE_SCALE_RST = 20'd307430;

  localparam logic [7:0] HEADER_ROM [16] = '{
    8'h41, 8'h88, 8'h00, 8'hCA, 8'hDE, 8'h56, 8'h45, 8'h57,
    8'h41, 8'hE1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef enum logic [1:0] {
    MODE_BYTE = 2'd0,
    MODE_END  = 2'd1,
    MODE_LOST = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [0:0] {
    CFG_OFFSET_SCALE   = 1'b0,
    CFG_DISTANCE_SCALE = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic take_byte;
    logic take_match;
    logic take_miss;
    logic take_lost;
    logic mul_p;
    logic mul_hi;
    logic mul_lo;
    logic corr;
    logic sum;
    logic mag;
    logic scale;
    logic emit;
  } sstwr_cmd_t;

  typedef struct packed {
    logic frame_ok;
  } sstwr_status_t;

endpackage

`default_nettype wire

@@ rtl/sstwr_ifs.sv @@
// Frame input and range result channel interfaces
`default_nettype none

interface sstwr_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [7:0]         rx_byte;
  logic [6:0]         frame_length;
  logic [31:0]        poll_send_time;
  logic [31:0]        resp_recv_time;
  logic signed [20:0] carrier_integ;

  modport source (
    output valid, mode, rx_byte, frame_length, poll_send_time, resp_recv_time,
           carrier_integ,
    input  ready
  );
  modport sink (
    input  valid, mode, rx_byte, frame_length, poll_send_time, resp_recv_time,
           carrier_integ,
    output ready
  );
endinterface

interface sstwr_out_if;
  logic               valid;
  logic               ready;
  logic               frame_match;
  logic               timed_out;
  logic signed [31:0] flight_ticks;
  logic signed [31:0] distance_mm;
  logic [31:0]        matched_total;
  logic [31:0]        lost_total;

  modport source (
    output valid, frame_match, timed_out, flight_ticks, distance_mm, matched_total,
           lost_total,
    input  ready
  );
  modport sink (
    input  valid, frame_match, timed_out, flight_ticks, distance_mm, matched_total,
           lost_total,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/sstwr_ctrl.sv @@
// Controller: sequences byte intake, frame-end range steps and result handoff
`default_nettype none

module sstwr_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    frame_valid,
  input  wire logic [1:0]              frame_mode,
  input  wire logic                    result_ready,
  input  wire sstwr_pkg::sstwr_status_t status,
  output logic                         frame_ready,
  output logic                         result_valid,
  output sstwr_pkg::sstwr_cmd_t        cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_MULP, S_MULHI, S_MULLO, S_CORR, S_SUM, S_MAG, S_SCALE, S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   take;
  logic   emit_ok;

  assign frame_ready = (state == S_IDLE);
  assign take        = frame_valid && frame_ready;
  assign emit_ok     = (state == S_EMIT) && (!result_valid || result_ready);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          unique case (frame_mode)
            sstwr_pkg::MODE_BYTE: cmd.take_byte = 1'b1;
            sstwr_pkg::MODE_END: begin
              if (status.frame_ok) begin
                cmd.take_match = 1'b1;
                state_next     = S_MULP;
              end else begin
                cmd.take_miss = 1'b1;
                state_next    = S_EMIT;
              end
            end
            sstwr_pkg::MODE_LOST: begin
              cmd.take_lost = 1'b1;
              state_next    = S_EMIT;
            end
            default: ;
          endcase
        end
      end
      S_MULP: begin
        cmd.mul_p  = 1'b1;
        state_next = S_MULHI;
      end
      S_MULHI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_MULLO;
      end
      S_MULLO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_CORR;
      end
      S_CORR: begin
        cmd.corr   = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_MAG;
      end
      S_MAG: begin
        cmd.mag    = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (emit_ok) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_ok) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/sstwr_dp.sv @@
// Datapath: header check, timestamp capture, offset correction and range math
`default_nettype none

module sstwr_dp (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire sstwr_pkg::sstwr_cmd_t    cmd,
  output sstwr_pkg::sstwr_status_t      status,
  input  wire logic [7:0]               rx_byte,
  input  wire logic [6:0]               frame_length,
  input  wire logic [31:0]              poll_send_time,
  input  wire logic [31:0]              resp_recv_time,
  input  wire logic signed [20:0]       carrier_integ,
  input  wire logic                     cfg_wr_en,
  input  wire logic [0:0]               cfg_index,
  input  wire logic [sstwr_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                          frame_match,
  output logic                          timed_out,
  output logic signed [31:0]            flight_ticks,
  output logic signed [31:0]            distance_mm,
  output logic [31:0]                   matched_total,
  output logic [31:0]                   lost_total
);

  function automatic logic [31:0] sat_signed(input logic [39:0] m, input logic neg);
    return neg ? ((m > 40'h00_8000_0000) ? 32'h8000_0000 : 32'(-m[31:0]))
               : ((m > 40'h00_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0]);
  endfunction

  logic signed [23:0] offset_scale;
  logic [19:0]        distance_scale;
  logic [4:0]         byte_position;
  logic               header_bad;
  logic [31:0]        remote_poll_recv;
  logic [31:0]        remote_resp_send;
  logic [31:0]        matched_count;
  logic [31:0]        lost_count;

  logic [31:0] local_turn;
  logic [31:0] remote_turn;
  logic [31:0] rtd_mag;
  logic [20:0] carrier_mag;
  logic [23:0] scale_mag;
  logic        corr_neg;
  logic        res_match;
  logic        res_lost;
  logic [51:0] p_prod;
  logic [51:0] hi_prod;
  logic [47:0] lo_prod;
  logic [35:0] corr_mag;
  logic signed [35:0] dbl_flight;
  logic [35:0] dbl_mag;
  logic        dbl_neg;
  logic [55:0] dist_prod;

  logic [31:0]        remote_turn_w;
  logic [31:0]        rtd_mag_w;
  logic [20:0]        carrier_mag_w;
  logic [23:0]        scale_mag_w;
  logic [51:0]        p_full;
  logic [51:0]        hi_full;
  logic [47:0]        lo_full;
  logic [48:0]        r_sum;
  logic [35:0]        q_w;
  logic signed [35:0] ext_init;
  logic signed [35:0] ext_resp;
  logic signed [35:0] corr_s;
  logic [55:0]        dist_full;
  logic [35:0]        fm;
  logic [39:0]        mm;
  logic               frame_end;
  logic               hdr_check;
  logic [1:0]         lane_poll;
  logic [1:0]         lane_resp;

  assign status.frame_ok = !header_bad
                         && (byte_position >= 5'(sstwr_pkg::HEADER_BYTES))
                         && (frame_length <= 7'(sstwr_pkg::BUFFER_BYTES));

  assign frame_end = cmd.take_match || cmd.take_miss || cmd.take_lost;
  assign hdr_check = (byte_position < 5'(sstwr_pkg::HEADER_BYTES))
                   && (byte_position != 5'(sstwr_pkg::SEQ_POS));
  assign lane_poll = 2'(byte_position - 5'(sstwr_pkg::POLL_POS));
  assign lane_resp = 2'(byte_position - 5'(sstwr_pkg::RESP_POS));

  assign remote_turn_w = remote_resp_send - remote_poll_recv;
  assign rtd_mag_w     = remote_turn_w[31] ? (-remote_turn_w) : remote_turn_w;
  assign carrier_mag_w = carrier_integ[20] ? 21'(-carrier_integ) : 21'(carrier_integ);
  assign scale_mag_w   = offset_scale[23] ? 24'(-offset_scale) : 24'(offset_scale);

  assign p_full    = 52'(rtd_mag) * 52'(carrier_mag);
  assign hi_full   = 52'(p_prod[51:24]) * 52'(scale_mag);
  assign lo_full   = 48'(p_prod[23:0]) * 48'(scale_mag);
  assign r_sum     = 49'({hi_prod[15:0], 24'h00_0000}) + 49'(lo_prod);
  assign q_w       = hi_prod[51:16] + 36'(r_sum[48:40]) + 36'(r_sum[39]);
  assign ext_init  = 36'(signed'(local_turn));
  assign ext_resp  = 36'(signed'(remote_turn));
  assign corr_s    = corr_neg ? -signed'(corr_mag) : signed'(corr_mag);
  assign dist_full = 56'(dbl_mag) * 56'(distance_scale);
  assign fm        = 36'(dbl_mag[35:1]) + 36'(dbl_mag[0]);
  assign mm        = 40'(dist_prod[55:17]) + 40'(dist_prod[16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_scale     <= sstwr_pkg::OFFSET_SCALE_RST;
      distance_scale   <= sstwr_pkg::DISTANCE_SCALE_RST;
      byte_position    <= '0;
      header_bad       <= 1'b0;
      remote_poll_recv <= '0;
      remote_resp_send <= '0;
      matched_count    <= '0;
      lost_count       <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          sstwr_pkg::CFG_OFFSET_SCALE:   offset_scale   <= signed'(cfg_data[23:0]);
          sstwr_pkg::CFG_DISTANCE_SCALE: distance_scale <= cfg_data[19:0];
          default: ;
        endcase
      end
      if (cmd.take_byte) begin
        if (hdr_check && (rx_byte != sstwr_pkg::HEADER_ROM[byte_position[3:0]])) begin
          header_bad <= 1'b1;
        end
        if (byte_position < 5'(sstwr_pkg::BUFFER_BYTES)) begin
          if (byte_position >= 5'(sstwr_pkg::POLL_POS)
              && byte_position < 5'(sstwr_pkg::POLL_POS + 4)) begin
            remote_poll_recv[lane_poll*8 +: 8] <= rx_byte;
          end else if (byte_position >= 5'(sstwr_pkg::RESP_POS)
                       && byte_position < 5'(sstwr_pkg::RESP_POS + 4)) begin
            remote_resp_send[lane_resp*8 +: 8] <= rx_byte;
          end
        end
        if (byte_position != 5'h1F) begin
          byte_position <= byte_position + 5'd1;
        end
      end
      if (frame_end) begin
        byte_position <= '0;
        header_bad    <= 1'b0;
      end
      if (cmd.take_match) begin
        matched_count <= matched_count + 32'd1;
      end
      if (cmd.take_lost) begin
        lost_count <= lost_count + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_end) begin
      res_match   <= cmd.take_match;
      res_lost    <= cmd.take_lost;
      local_turn  <= resp_recv_time - poll_send_time;
      remote_turn <= remote_turn_w;
      rtd_mag     <= rtd_mag_w;
      carrier_mag <= carrier_mag_w;
      scale_mag   <= scale_mag_w;
      corr_neg    <= remote_turn_w[31] ^ carrier_integ[20] ^ offset_scale[23];
    end
    if (cmd.mul_p) begin
      p_prod <= p_full;
    end
    if (cmd.mul_hi) begin
      hi_prod <= hi_full;
    end
    if (cmd.mul_lo) begin
      lo_prod <= lo_full;
    end
    if (cmd.corr) begin
      corr_mag <= q_w;
    end
    if (cmd.sum) begin
      dbl_flight <= ext_init - ext_resp + corr_s;
    end
    if (cmd.mag) begin
      dbl_mag <= dbl_flight[35] ? 36'(-dbl_flight) : 36'(dbl_flight);
      dbl_neg <= dbl_flight[35];
    end
    if (cmd.scale) begin
      dist_prod <= dist_full;
    end
    if (cmd.emit) begin
      frame_match   <= res_match;
      timed_out     <= res_lost;
      flight_ticks  <= res_match ? signed'(sat_signed(40'(fm), dbl_neg)) : '0;
      distance_mm   <= res_match ? signed'(sat_signed(mm, dbl_neg)) : '0;
      matched_total <= matched_count;
      lost_total    <= lost_count;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ss_twr_response_range.sv @@
// Frame bytes: one transaction per cycle while idle, no result.
// Good frame end: result registered in EMIT after MULP, MULHI, MULLO, CORR, SUM, MAG
// and SCALE (four-multiply correction and scaling chain); next transaction accepted on
// return to IDLE. Mismatch or timeout: straight to EMIT; a waiting result stalls both.
// Reset (rst, synchronous): clears counters, byte position and result valid,
// restores both scale registers.
`default_nettype none

module ss_twr_response_range (
  input  wire logic      clk,
  input  wire logic      rst,
  sstwr_in_if.sink       frame,
  sstwr_out_if.source    result,
  input  wire logic      cfg_wr_en,
  input  wire logic [0:0] cfg_index,
  input  wire logic [sstwr_pkg::CFG_DATA_W-1:0] cfg_data
);

  sstwr_pkg::sstwr_cmd_t    cmd;
  sstwr_pkg::sstwr_status_t status;
  logic                     frame_ready;
  logic                     result_valid;

  assign frame.ready  = frame_ready;
  assign result.valid = result_valid;

  sstwr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame.valid),
    .frame_mode   (frame.mode),
    .result_ready (result.ready),
    .status       (status),
    .frame_ready  (frame_ready),
    .result_valid (result_valid),
    .cmd          (cmd)
  );

  sstwr_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .rx_byte        (frame.rx_byte),
    .frame_length   (frame.frame_length),
    .poll_send_time (frame.poll_send_time),
    .resp_recv_time (frame.resp_recv_time),
    .carrier_integ  (frame.carrier_integ),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .frame_match    (result.frame_match),
    .timed_out      (result.timed_out),
    .flight_ticks   (result.flight_ticks),
    .distance_mm    (result.distance_mm),
    .matched_total  (result.matched_total),
    .lost_total     (result.lost_total)
  );

endmodule

`default_nettype wire

@@ rtl/sstwr_chk.sv @@
// Port-level checker for the ranging response block, bound to the top level
`default_nettype none
`include "ss_twr_response_range_macros.svh"

module sstwr_chk (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               frame_valid,
  input wire logic               frame_ready,
  input wire logic [1:0]         frame_mode,
  input wire logic               result_valid,
  input wire logic               result_ready,
  input wire logic               frame_match,
  input wire logic               timed_out,
  input wire logic signed [31:0] flight_ticks,
  input wire logic signed [31:0] distance_mm,
  input wire logic [31:0]        matched_total
);

  logic frame_end_taken;

  assign frame_end_taken = frame_valid && frame_ready
                         && (frame_mode == sstwr_pkg::MODE_END
                             || frame_mode == sstwr_pkg::MODE_LOST);

  `SSTWR_ASSERT_NOW(a_kind_excl, result_valid, !(frame_match && timed_out))
  `SSTWR_ASSERT_NOW(a_nomatch_zero, result_valid && !frame_match, flight_ticks == 0 && distance_mm == 0)
  `SSTWR_ASSERT_NEXT(a_busy_after_end, frame_end_taken, !frame_ready)
  `SSTWR_ASSERT_NEXT(a_stall_hold, result_valid && !result_ready, result_valid && $stable(matched_total) && $stable(flight_ticks))

endmodule

bind ss_twr_response_range sstwr_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .frame_valid   (frame.valid),
  .frame_ready   (frame.ready),
  .frame_mode    (frame.mode),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .frame_match   (result.frame_match),
  .timed_out     (result.timed_out),
  .flight_ticks  (result.flight_ticks),
  .distance_mm   (result.distance_mm),
  .matched_total (result.matched_total)
);

`default_nettype wire
